/* rtl/core/box_plane_penetration_unit_macros.svh */
// Assertion macros used by the penetration unit checker
`ifndef BOX_PLANE_PENETRATION_UNIT_MACROS_SVH
`define BOX_PLANE_PENETRATION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset
`define BPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpp assertion failed");

// Next-cycle implication, sampled on clk_i, off while in reset
`define BPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpp assertion failed");

`endif

/* rtl/core/bpp_pkg.sv */
// Types and constants for the box/plane penetration datapath
package bpp_pkg;

  localparam int CompW     = 16;  // Q1.14 unit components
  localparam int LenW      = 32;  // Q16.16 positions
  localparam int SizeW     = 31;  // Q15.16 unsigned lengths
  localparam int ProdW     = 32;  // quaternion pair products
  localparam int NcW       = 48;  // normal times centre
  localparam int RotW      = 35;  // rotation entries, Q28
  localparam int MW        = 51;  // normal times rotation entry
  localparam int GW        = 54;  // projected axis, Q42
  localparam int EW        = 26;  // rounded axis magnitude, Q14
  localparam int ExtW      = 57;  // half-extent term per axis
  localparam int AccW      = 62;  // distance accumulator, Q31
  localparam int FracShift = 15;  // Q31 -> Q16.16
  localparam int RoundSh   = 28;  // Q42 -> Q14
  localparam int NumStg    = 6;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [LenW-1:0]  len_t;
  typedef logic        [SizeW-1:0] size_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [NcW-1:0]   nc_t;
  typedef logic signed [RotW-1:0]  rot_t;
  typedef logic signed [MW-1:0]    m_t;
  typedef logic signed [GW-1:0]    g_t;
  typedef logic        [GW-1:0]    mag_t;
  typedef logic        [EW-1:0]    e_t;
  typedef logic        [ExtW-1:0]  ext_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef struct packed {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    len_t  d;
  } plane_t;

  // Load enables for the two register stages inside one datapath module
  typedef struct packed {
    logic first;
    logic second;
  } stg_en_t;

  typedef enum logic [1:0] {
    RegNormalX = 2'd0,
    RegNormalY = 2'd1,
    RegNormalZ = 2'd2,
    RegOffset  = 2'd3
  } cfg_reg_e;

  localparam comp_t NormalZReset = 16'sd16384;
  localparam rot_t  OneQ28       = rot_t'(1) <<< RoundSh;
  localparam mag_t  RoundHalf    = mag_t'(1) << (RoundSh - 1);

endpackage

/* rtl/core/bpp_front.sv */
// Stages 1-2: quaternion products, rotation matrix, plane distance of the centre
module bpp_front (
  input  logic             clk_i,
  input  bpp_pkg::stg_en_t en_i,
  input  bpp_pkg::plane_t  plane_i,
  input  bpp_pkg::len_t    center_x_i,
  input  bpp_pkg::len_t    center_y_i,
  input  bpp_pkg::len_t    center_z_i,
  input  bpp_pkg::size_t   size_x_i,
  input  bpp_pkg::size_t   size_y_i,
  input  bpp_pkg::size_t   size_z_i,
  input  bpp_pkg::comp_t   rot_w_i,
  input  bpp_pkg::comp_t   rot_x_i,
  input  bpp_pkg::comp_t   rot_y_i,
  input  bpp_pkg::comp_t   rot_z_i,
  output bpp_pkg::rot_t    r_o [9],
  output bpp_pkg::acc_t    base_o,
  output bpp_pkg::size_t   size_o [3]
);

  bpp_pkg::prod_t xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  bpp_pkg::nc_t   nc_q [3];
  bpp_pkg::size_t s1_size_q [3];

  bpp_pkg::rot_t  r_d [9];
  bpp_pkg::rot_t  r_q [9];
  bpp_pkg::acc_t  base_d, base_q;
  bpp_pkg::size_t s2_size_q [3];

  // Stage 1: the nine quaternion pair products the matrix needs (all but w*w) and the normal/centre products
  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      xx_q <= bpp_pkg::ProdW'(rot_x_i) * bpp_pkg::ProdW'(rot_x_i);
      yy_q <= bpp_pkg::ProdW'(rot_y_i) * bpp_pkg::ProdW'(rot_y_i);
      zz_q <= bpp_pkg::ProdW'(rot_z_i) * bpp_pkg::ProdW'(rot_z_i);
      xy_q <= bpp_pkg::ProdW'(rot_x_i) * bpp_pkg::ProdW'(rot_y_i);
      xz_q <= bpp_pkg::ProdW'(rot_x_i) * bpp_pkg::ProdW'(rot_z_i);
      yz_q <= bpp_pkg::ProdW'(rot_y_i) * bpp_pkg::ProdW'(rot_z_i);
      wx_q <= bpp_pkg::ProdW'(rot_w_i) * bpp_pkg::ProdW'(rot_x_i);
      wy_q <= bpp_pkg::ProdW'(rot_w_i) * bpp_pkg::ProdW'(rot_y_i);
      wz_q <= bpp_pkg::ProdW'(rot_w_i) * bpp_pkg::ProdW'(rot_z_i);
      nc_q[0] <= bpp_pkg::NcW'(plane_i.nx) * bpp_pkg::NcW'(center_x_i);
      nc_q[1] <= bpp_pkg::NcW'(plane_i.ny) * bpp_pkg::NcW'(center_y_i);
      nc_q[2] <= bpp_pkg::NcW'(plane_i.nz) * bpp_pkg::NcW'(center_z_i);
      s1_size_q[0] <= size_x_i;
      s1_size_q[1] <= size_y_i;
      s1_size_q[2] <= size_z_i;
    end
  end

  // Stage 2: rotation matrix in Q28, row major
  always_comb begin
    r_d[0] = bpp_pkg::OneQ28 -
             ((bpp_pkg::rot_t'(yy_q) + bpp_pkg::rot_t'(zz_q)) <<< 1);
    r_d[1] = (bpp_pkg::rot_t'(xy_q) - bpp_pkg::rot_t'(wz_q)) <<< 1;
    r_d[2] = (bpp_pkg::rot_t'(xz_q) + bpp_pkg::rot_t'(wy_q)) <<< 1;
    r_d[3] = (bpp_pkg::rot_t'(xy_q) + bpp_pkg::rot_t'(wz_q)) <<< 1;
    r_d[4] = bpp_pkg::OneQ28 -
             ((bpp_pkg::rot_t'(xx_q) + bpp_pkg::rot_t'(zz_q)) <<< 1);
    r_d[5] = (bpp_pkg::rot_t'(yz_q) - bpp_pkg::rot_t'(wx_q)) <<< 1;
    r_d[6] = (bpp_pkg::rot_t'(xz_q) - bpp_pkg::rot_t'(wy_q)) <<< 1;
    r_d[7] = (bpp_pkg::rot_t'(yz_q) + bpp_pkg::rot_t'(wx_q)) <<< 1;
    r_d[8] = bpp_pkg::OneQ28 -
             ((bpp_pkg::rot_t'(xx_q) + bpp_pkg::rot_t'(yy_q)) <<< 1);
    // Centre distance in Q31
    base_d = ((bpp_pkg::acc_t'(nc_q[0]) + bpp_pkg::acc_t'(nc_q[1]) +
               bpp_pkg::acc_t'(nc_q[2])) <<< 1) +
             (bpp_pkg::acc_t'(plane_i.d) <<< bpp_pkg::FracShift);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      r_q       <= r_d;
      base_q    <= base_d;
      s2_size_q <= s1_size_q;
    end
  end

  assign r_o    = r_q;
  assign base_o = base_q;
  assign size_o = s2_size_q;

endmodule

/* rtl/core/bpp_axis.sv */
// Stages 3-4: project each box axis on the plane normal, round to Q14
module bpp_axis (
  input  logic             clk_i,
  input  bpp_pkg::stg_en_t en_i,
  input  bpp_pkg::plane_t  plane_i,
  input  bpp_pkg::rot_t    r_i [9],
  input  bpp_pkg::acc_t    base_i,
  input  bpp_pkg::size_t   size_i [3],
  output bpp_pkg::e_t      e_o [3],
  output bpp_pkg::acc_t    base_o,
  output bpp_pkg::size_t   size_o [3]
);

  bpp_pkg::comp_t n_arr [3];
  bpp_pkg::m_t    m_d [9];
  bpp_pkg::m_t    m_q [9];
  bpp_pkg::acc_t  s3_base_q, s4_base_q;
  bpp_pkg::size_t s3_size_q [3];
  bpp_pkg::size_t s4_size_q [3];
  bpp_pkg::g_t    g_d [3];
  bpp_pkg::mag_t  mag_d [3];
  bpp_pkg::e_t    e_d [3];
  bpp_pkg::e_t    e_q [3];

  assign n_arr[0] = plane_i.nx;
  assign n_arr[1] = plane_i.ny;
  assign n_arr[2] = plane_i.nz;

  // Stage 3: nine products n_i * R_ij
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_d[i*3+j] = bpp_pkg::MW'(n_arr[i]) * bpp_pkg::MW'(r_i[i*3+j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      m_q       <= m_d;
      s3_base_q <= base_i;
      s3_size_q <= size_i;
    end
  end

  // Stage 4: column sums, magnitude, round half up to Q14
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      g_d[j]   = bpp_pkg::g_t'(m_q[j]) + bpp_pkg::g_t'(m_q[3+j]) +
                 bpp_pkg::g_t'(m_q[6+j]);
      mag_d[j] = g_d[j][bpp_pkg::GW-1] ? bpp_pkg::mag_t'(-g_d[j])
                                       : bpp_pkg::mag_t'(g_d[j]);
      e_d[j]   = bpp_pkg::EW'((mag_d[j] + bpp_pkg::RoundHalf) >> bpp_pkg::RoundSh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      e_q       <= e_d;
      s4_base_q <= s3_base_q;
      s4_size_q <= s3_size_q;
    end
  end

  assign e_o    = e_q;
  assign base_o = s4_base_q;
  assign size_o = s4_size_q;

endmodule

/* rtl/core/bpp_depth.sv */
// Stages 5-6: half-extent terms, minimum corner distance, clamp and saturate
module bpp_depth (
  input  logic             clk_i,
  input  bpp_pkg::stg_en_t en_i,
  input  bpp_pkg::e_t      e_i [3],
  input  bpp_pkg::size_t   size_i [3],
  input  bpp_pkg::acc_t    base_i,
  output bpp_pkg::len_t    penetration_o
);

  bpp_pkg::ext_t ext_q [3];
  bpp_pkg::acc_t s5_base_q;
  logic [bpp_pkg::AccW-1:0] ext_sum;
  bpp_pkg::acc_t acc_d, shr_d;
  bpp_pkg::len_t pen_d, pen_q;

  // Stage 5: e_j * s_j (full-length sizes, so this is already twice the half extent)
  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      for (int j = 0; j < 3; j++) begin
        ext_q[j] <= bpp_pkg::ExtW'(e_i[j]) * bpp_pkg::ExtW'(size_i[j]);
      end
      s5_base_q <= base_i;
    end
  end

  // Stage 6: worst corner, floor to Q16.16, clamp to [-2^31, 0]
  always_comb begin
    ext_sum = bpp_pkg::AccW'(ext_q[0]) + bpp_pkg::AccW'(ext_q[1]) +
              bpp_pkg::AccW'(ext_q[2]);
    acc_d   = s5_base_q - $signed(ext_sum);
    shr_d   = acc_d >>> bpp_pkg::FracShift;
    if (!shr_d[bpp_pkg::AccW-1]) begin
      pen_d = '0;
    end else if (&shr_d[bpp_pkg::AccW-1:bpp_pkg::LenW-1]) begin
      pen_d = shr_d[bpp_pkg::LenW-1:0];
    end else begin
      pen_d = {1'b1, {(bpp_pkg::LenW-1){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      pen_q <= pen_d;
    end
  end

  assign penetration_o = pen_q;

endmodule

/* rtl/core/box_plane_penetration_unit.sv */
// Top level: oriented box against configured plane, penetration depth
//
// Takes one oriented box per clock while in_stall_o is low and returns its
// penetration depth below the configured plane (Q16.16, never positive,
// saturating at the most negative value). The result passes through the six
// register stages of the datapath (products, rotation, projection, rounding,
// extent, reduction) into the output register. Throughput is one transaction
// per cycle when no stall holds it. A stalled output only backs up the stages
// behind it; empty stages keep filling. Plane registers are to be written by
// the user only while idle; the block itself does not enforce this.
module box_plane_penetration_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bpp_pkg::len_t  center_x_i,
  input  bpp_pkg::len_t  center_y_i,
  input  bpp_pkg::len_t  center_z_i,
  input  bpp_pkg::size_t size_x_i,
  input  bpp_pkg::size_t size_y_i,
  input  bpp_pkg::size_t size_z_i,
  input  bpp_pkg::comp_t rot_w_i,
  input  bpp_pkg::comp_t rot_x_i,
  input  bpp_pkg::comp_t rot_y_i,
  input  bpp_pkg::comp_t rot_z_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bpp_pkg::len_t  penetration_o
);

  bpp_pkg::plane_t plane_q;

  logic [bpp_pkg::NumStg-1:0] valid_q;
  logic [bpp_pkg::NumStg:0]   stg_en;

  bpp_pkg::stg_en_t front_en, axis_en, depth_en;

  bpp_pkg::rot_t  rot_mat [9];
  bpp_pkg::acc_t  front_base, axis_base;
  bpp_pkg::size_t front_size [3];
  bpp_pkg::size_t axis_size [3];
  bpp_pkg::e_t    axis_e [3];

  // Plane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.nx <= '0;
      plane_q.ny <= '0;
      plane_q.nz <= bpp_pkg::NormalZReset;
      plane_q.d  <= '0;
    end else if (cfg_we_i) begin
      unique case (bpp_pkg::cfg_reg_e'(cfg_index_i))
        bpp_pkg::RegNormalX: plane_q.nx <= cfg_wdata_i[bpp_pkg::CompW-1:0];
        bpp_pkg::RegNormalY: plane_q.ny <= cfg_wdata_i[bpp_pkg::CompW-1:0];
        bpp_pkg::RegNormalZ: plane_q.nz <= cfg_wdata_i[bpp_pkg::CompW-1:0];
        bpp_pkg::RegOffset:  plane_q.d  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it moves on
  always_comb begin
    stg_en[bpp_pkg::NumStg] = !out_stall_i;
    for (int k = bpp_pkg::NumStg - 1; k >= 0; k--) begin
      stg_en[k] = !valid_q[k] || stg_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stg_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < bpp_pkg::NumStg; k++) begin
        if (stg_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign front_en.first  = stg_en[0];
  assign front_en.second = stg_en[1];
  assign axis_en.first   = stg_en[2];
  assign axis_en.second  = stg_en[3];
  assign depth_en.first  = stg_en[4];
  assign depth_en.second = stg_en[5];

  assign in_stall_o  = !stg_en[0];
  assign out_valid_o = valid_q[bpp_pkg::NumStg-1];

  bpp_front u_front (
    .clk_i      (clk_i),
    .en_i       (front_en),
    .plane_i    (plane_q),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .center_z_i (center_z_i),
    .size_x_i   (size_x_i),
    .size_y_i   (size_y_i),
    .size_z_i   (size_z_i),
    .rot_w_i    (rot_w_i),
    .rot_x_i    (rot_x_i),
    .rot_y_i    (rot_y_i),
    .rot_z_i    (rot_z_i),
    .r_o        (rot_mat),
    .base_o     (front_base),
    .size_o     (front_size)
  );

  bpp_axis u_axis (
    .clk_i   (clk_i),
    .en_i    (axis_en),
    .plane_i (plane_q),
    .r_i     (rot_mat),
    .base_i  (front_base),
    .size_i  (front_size),
    .e_o     (axis_e),
    .base_o  (axis_base),
    .size_o  (axis_size)
  );

  bpp_depth u_depth (
    .clk_i         (clk_i),
    .en_i          (depth_en),
    .e_i           (axis_e),
    .size_i        (axis_size),
    .base_i        (axis_base),
    .penetration_o (penetration_o)
  );

endmodule

/* rtl/core/bpp_checker.sv */
// Port-level checks for the penetration unit, bound to the top level
`include "box_plane_penetration_unit_macros.svh"

module bpp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bpp_pkg::len_t penetration_o
);

  // receiver holding out_stall_i low without a break
  sequence s_flow6;
    !out_stall_i [*6];
  endsequence

  // Depth is never above the plane
  `BPP_ASSERT_NOW(a_pen_nonpos, out_valid_o, penetration_o[31] || penetration_o == 0)

  // With the output register empty, every stage can load
  `BPP_ASSERT_NOW(a_empty_accepts, !out_valid_o, !in_stall_o)

  // After an accepted transaction, with the receiver never stalling, a result is shown
  `BPP_ASSERT_NEXT(a_latency, (in_valid_i && !in_stall_o) ##0 s_flow6, out_valid_o)

  `BPP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  `BPP_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(penetration_o))

endmodule

bind box_plane_penetration_unit bpp_checker u_bpp_checker (.*);

/* bench/tb_top.sv */
// Self-checking testbench for the box/plane penetration unit
`timescale 1ns / 1ps

module tb_top;

  localparam int     WatchdogLimit  = 5000;
  localparam int     LongHoldCycles = 400;
  localparam int     NumPhases      = 8;
  localparam int     BoxesPerPhase  = 150;
  localparam longint Q28One         = 64'sd1 <<< bpp_pkg::RoundSh;

  typedef struct packed {
    bpp_pkg::len_t  cx;
    bpp_pkg::len_t  cy;
    bpp_pkg::len_t  cz;
    bpp_pkg::size_t sx;
    bpp_pkg::size_t sy;
    bpp_pkg::size_t sz;
    bpp_pkg::comp_t w;
    bpp_pkg::comp_t x;
    bpp_pkg::comp_t y;
    bpp_pkg::comp_t z;
  } box_t;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           cfg_we_i    = 1'b0;
  logic [1:0]     cfg_index_i = bpp_pkg::RegNormalX;
  logic [31:0]    cfg_wdata_i = '0;
  logic           in_valid_i  = 1'b0;
  bpp_pkg::len_t  center_x_i  = '0;
  bpp_pkg::len_t  center_y_i  = '0;
  bpp_pkg::len_t  center_z_i  = '0;
  bpp_pkg::size_t size_x_i    = '0;
  bpp_pkg::size_t size_y_i    = '0;
  bpp_pkg::size_t size_z_i    = '0;
  bpp_pkg::comp_t rot_w_i     = '0;
  bpp_pkg::comp_t rot_x_i     = '0;
  bpp_pkg::comp_t rot_y_i     = '0;
  bpp_pkg::comp_t rot_z_i     = '0;
  logic           out_stall_i = 1'b0;
  logic           in_stall_o;
  logic           out_valid_o;
  bpp_pkg::len_t  penetration_o;

  // plane as the block should hold it
  bpp_pkg::comp_t plane_nx = 16'sd0;
  bpp_pkg::comp_t plane_ny = 16'sd0;
  bpp_pkg::comp_t plane_nz = bpp_pkg::NormalZReset;
  bpp_pkg::len_t  plane_d  = 32'sd0;

  box_t          pending_boxes[$];
  bpp_pkg::len_t expected_depths[$];
  box_t          offered_box;
  box_t          accepted_box;
  bpp_pkg::len_t expected_depth;
  logic          offering = 1'b0;

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int rx_hold_left  = 0;
  int idle_cycles   = 0;
  int boxes_sent    = 0;
  int depths_seen   = 0;
  int zero_depths   = 0;
  int sat_depths    = 0;
  int errors        = 0;

  box_plane_penetration_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .center_z_i   (center_z_i),
    .size_x_i     (size_x_i),
    .size_y_i     (size_y_i),
    .size_z_i     (size_z_i),
    .rot_w_i      (rot_w_i),
    .rot_x_i      (rot_x_i),
    .rot_y_i      (rot_y_i),
    .rot_z_i      (rot_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .penetration_o(penetration_o)
  );

  always #2 clk_i = ~clk_i;

  // |g| in Q42 rounded half up to Q14
  function automatic longint round_q14(longint g);
    longint mag;
    mag = (g < 0) ? -g : g;
    return (mag + (64'sd1 <<< (bpp_pkg::RoundSh - 1))) >>> bpp_pkg::RoundSh;
  endfunction

  function automatic bpp_pkg::len_t predict_depth(box_t b);
    longint w, x, y, z, nx, ny, nz;
    longint gx, gy, gz, extent, acc, q;
    w  = longint'(b.w);
    x  = longint'(b.x);
    y  = longint'(b.y);
    z  = longint'(b.z);
    nx = longint'(plane_nx);
    ny = longint'(plane_ny);
    nz = longint'(plane_nz);
    // normal projected on each rotated box axis, Q42
    gx = nx * (Q28One - 2 * (y * y + z * z)) + ny * (2 * (x * y + w * z))
       + nz * (2 * (x * z - w * y));
    gy = nx * (2 * (x * y - w * z)) + ny * (Q28One - 2 * (x * x + z * z))
       + nz * (2 * (y * z + w * x));
    gz = nx * (2 * (x * z + w * y)) + ny * (2 * (y * z - w * x))
       + nz * (Q28One - 2 * (x * x + y * y));
    extent = round_q14(gx) * longint'(b.sx) + round_q14(gy) * longint'(b.sy)
           + round_q14(gz) * longint'(b.sz);
    acc = 2 * (nx * longint'(b.cx) + ny * longint'(b.cy) + nz * longint'(b.cz))
        + longint'(plane_d) * 32768 - extent;
    q = acc >>> bpp_pkg::FracShift;
    if (q > 0) begin
      q = 0;
    end
    if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
    end
    return bpp_pkg::len_t'(q);
  endfunction

  function automatic box_t rand_box();
    box_t b;
    if ($urandom_range(99) < 30) begin
      // anything the fields allow
      b.cx = bpp_pkg::len_t'($urandom);
      b.cy = bpp_pkg::len_t'($urandom);
      b.cz = bpp_pkg::len_t'($urandom);
      b.sx = bpp_pkg::size_t'($urandom);
      b.sy = bpp_pkg::size_t'($urandom);
      b.sz = bpp_pkg::size_t'($urandom);
      b.w  = bpp_pkg::comp_t'($urandom);
      b.x  = bpp_pkg::comp_t'($urandom);
      b.y  = bpp_pkg::comp_t'($urandom);
      b.z  = bpp_pkg::comp_t'($urandom);
    end else begin
      // boxes near the plane, so depths land between zero and saturation
      b.cx = bpp_pkg::len_t'(int'($urandom_range(33554432)) - 16777216);
      b.cy = bpp_pkg::len_t'(int'($urandom_range(33554432)) - 16777216);
      b.cz = bpp_pkg::len_t'(int'($urandom_range(33554432)) - 16777216);
      b.sx = bpp_pkg::size_t'($urandom_range(4194304));
      b.sy = bpp_pkg::size_t'($urandom_range(4194304));
      b.sz = bpp_pkg::size_t'($urandom_range(4194304));
      b.w  = bpp_pkg::comp_t'(int'($urandom_range(32768)) - 16384);
      b.x  = bpp_pkg::comp_t'(int'($urandom_range(32768)) - 16384);
      b.y  = bpp_pkg::comp_t'(int'($urandom_range(32768)) - 16384);
      b.z  = bpp_pkg::comp_t'(int'($urandom_range(32768)) - 16384);
    end
    return b;
  endfunction

  task automatic add_box(input bpp_pkg::len_t cx, input bpp_pkg::len_t cy,
                         input bpp_pkg::len_t cz,
                         input bpp_pkg::size_t sx, input bpp_pkg::size_t sy,
                         input bpp_pkg::size_t sz,
                         input bpp_pkg::comp_t w, input bpp_pkg::comp_t x,
                         input bpp_pkg::comp_t y, input bpp_pkg::comp_t z);
    box_t b;
    b = '{cx: cx, cy: cy, cz: cz, sx: sx, sy: sy, sz: sz, w: w, x: x, y: y, z: z};
    pending_boxes.insert(pending_boxes.size(), b);
  endtask

  // only called with nothing in flight
  task automatic write_plane_reg(input bpp_pkg::cfg_reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= (idx == bpp_pkg::RegOffset) ? val : {16'($urandom), val[15:0]};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bpp_pkg::RegNormalX: plane_nx = bpp_pkg::comp_t'(val[15:0]);
      bpp_pkg::RegNormalY: plane_ny = bpp_pkg::comp_t'(val[15:0]);
      bpp_pkg::RegNormalZ: plane_nz = bpp_pkg::comp_t'(val[15:0]);
      default:             plane_d  = bpp_pkg::len_t'(val);
    endcase
  endtask

  task automatic wait_drained();
    while (pending_boxes.size() != 0 || expected_depths.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (bpp_pkg::NumStg + 4) @(posedge clk_i);
  endtask

  // driver: record accepted transactions and predict their depth
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      accepted_box = pending_boxes.pop_front();
      expected_depths.insert(expected_depths.size(), predict_depth(accepted_box));
      offering     = 1'b0;
      boxes_sent++;
    end
  end

  always @(negedge clk_i) begin
    if (!offering) begin
      if (rst_ni && pending_boxes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        offered_box = pending_boxes[0];
        center_x_i <= offered_box.cx;
        center_y_i <= offered_box.cy;
        center_z_i <= offered_box.cz;
        size_x_i   <= offered_box.sx;
        size_y_i   <= offered_box.sy;
        size_z_i   <= offered_box.sz;
        rot_w_i    <= offered_box.w;
        rot_x_i    <= offered_box.x;
        rot_y_i    <= offered_box.y;
        rot_z_i    <= offered_box.z;
        in_valid_i <= 1'b1;
        offering   = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: receiver stall and result check
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      depths_seen++;
      if (penetration_o == 32'sd0) begin
        zero_depths++;
      end
      if (penetration_o == 32'sh8000_0000) begin
        sat_depths++;
      end
      if (expected_depths.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: depth %0d with no transaction outstanding", penetration_o);
        end
      end else begin
        expected_depth = expected_depths.pop_front();
        if (penetration_o !== expected_depth) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: depth #%0d expected %0d (0x%08h) got %0d (0x%08h)",
                     depths_seen, expected_depth, expected_depth,
                     penetration_o, penetration_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("box_plane_penetration_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      case (p)
        0: ;  // plane straight out of reset
        1: begin
          write_plane_reg(bpp_pkg::RegNormalX, 32'h0000_8000);
          write_plane_reg(bpp_pkg::RegNormalY, 32'h0000_7FFF);
          write_plane_reg(bpp_pkg::RegNormalZ, 32'h0000_0000);
          write_plane_reg(bpp_pkg::RegOffset,  32'h8000_0000);
        end
        2: begin
          // zero normal: every corner sits at the offset
          write_plane_reg(bpp_pkg::RegNormalX, 32'h0000_0000);
          write_plane_reg(bpp_pkg::RegNormalY, 32'h0000_0000);
          write_plane_reg(bpp_pkg::RegOffset,  32'h7FFF_FFFF);
        end
        3: begin
          write_plane_reg(bpp_pkg::RegNormalX, 32'h0000_4000);
          write_plane_reg(bpp_pkg::RegNormalY, 32'h0000_C000);
          write_plane_reg(bpp_pkg::RegNormalZ, 32'h0000_4000);
          write_plane_reg(bpp_pkg::RegOffset,  32'h0000_0000);
        end
        default: begin
          write_plane_reg(bpp_pkg::RegNormalX, $urandom);
          write_plane_reg(bpp_pkg::RegNormalY, $urandom);
          write_plane_reg(bpp_pkg::RegNormalZ, $urandom);
          write_plane_reg(bpp_pkg::RegOffset,  $urandom);
        end
      endcase
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      if (p == 4) begin
        // receiver holds off while the sender keeps the input busy
        @(posedge clk_i);
        rx_hold_left = LongHoldCycles;
      end
      if (p == 0) begin
        add_box(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        add_box(0, 0, 32'sh0001_0000, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                16384, 0, 0, 0);
        add_box(0, 0, -32'sh0001_0000, 31'h0002_0000, 31'h0002_0000, 31'h0002_0000,
                16384, 0, 0, 0);
        add_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 16384, 0, 0, 0);
        // deep penetration, saturates
        add_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16384, 0, 0, 0);
        add_box(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16384, 0, 0, 0);
        add_box(0, 0, 0, 31'h0001_0000, 31'h0002_0000, 31'h0003_0000, 0, 16384, 0, 0);
        add_box(0, 0, 0, 31'h0001_0000, 31'h0002_0000, 31'h0003_0000, 0, 0, 16384, 0);
        add_box(0, 0, 0, 31'h0001_0000, 31'h0002_0000, 31'h0003_0000, 0, 0, 0, 16384);
        add_box(0, 0, 0, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 11585, 11585, 0, 0);
        // non-unit quaternions, used as given
        add_box(0, 0, 0, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                -32768, -32768, -32768, -32768);
        add_box(0, 0, 0, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                32767, 32767, 32767, 32767);
        add_box(0, 0, 32'sh0000_8000, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                0, 0, 0, 0);
        add_box(0, 0, 32'sh0000_8000, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                -16384, 0, 0, 0);
        add_box(0, 0, 0, 31'h0001_0000, 31'h0001_0000, 31'h0001_0000,
                16384, 16384, 16384, 16384);
        // fractional centre just below the plane
        add_box(32'sh1234_5678, -32'sh0765_4321, -32'sd3, 0, 0, 0, 16384, 0, 0, 0);
        // axis magnitude exactly on a rounding half
        add_box(0, 0, 32'sh0000_4000, 31'h0, 31'h0, 31'h0001_0000, 16384, 64, 0, 0);
      end
      repeat (BoxesPerPhase) pending_boxes.insert(pending_boxes.size(), rand_box());
    end
    wait_drained();

    if (expected_depths.size() != 0) begin
      errors += expected_depths.size();
      $display("ERROR: %0d depths never came out", expected_depths.size());
    end
    $display("covered %0d boxes over %0d plane settings and four stall patterns",
             boxes_sent, NumPhases);
    $display("%0d depths checked, %0d clamped at zero, %0d saturated, %0d errors",
             depths_seen, zero_depths, sat_depths, errors);
    if (errors == 0) begin
      $display("box_plane_penetration_unit: match");
    end else begin
      $display("box_plane_penetration_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bpp_pkg.sv
rtl/core/bpp_front.sv
rtl/core/bpp_axis.sv
rtl/core/bpp_depth.sv
rtl/core/box_plane_penetration_unit.sv
rtl/core/bpp_checker.sv
bench/tb_top.sv
